/* sv/sprite_blit_color_key_core_assert.svh */
// Assertion macros shared by the sprite blitter RTL.
`ifndef SPRITE_BLIT_COLOR_KEY_CORE_ASSERT_SVH
`define SPRITE_BLIT_COLOR_KEY_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SBCK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBCK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sbck_pkg.sv */
// Shared types and constants for the sprite blitter.
`default_nettype none
package sbck_pkg;

  localparam int unsigned LINE_PIXELS_DEF = 320;
  localparam int unsigned CLIP_ROW_DEF    = 479;

  localparam int unsigned COORD_W    = 9;
  localparam int unsigned ROW_W      = COORD_W + 1;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned ADDR_W     = 18;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned TDATA_W    = 32;
  localparam int unsigned IN_TDATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEST_X     = 3'd0,
    CFG_DEST_Y     = 3'd1,
    CFG_WIDTH      = 3'd2,
    CFG_HEIGHT     = 3'd3,
    CFG_SKIP_ZERO  = 3'd4,
    CFG_KEY_COLOR  = 3'd5,
    CFG_REPL_COLOR = 3'd6,
    CFG_MIRROR     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic [COORD_W-1:0] sprite_width;
    logic [COORD_W-1:0] sprite_height;
    logic               skip_zero;
    logic [PIX_W-1:0]   key_color;
    logic [PIX_W-1:0]   repl_color;
    logic               mirror;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [PIX_W-1:0]   color;
    logic [ROW_W-1:0]   screen_row;
    logic [COORD_W-1:0] col;
    logic               last;
  } scan_item_t;

endpackage
`default_nettype wire

/* sv/sbck_scan.sv */
// Sprite walk: column/row counters, color key, clipping and input register.
`default_nettype none
`include "sprite_blit_color_key_core_assert.svh"
module sbck_scan #(
  parameter int unsigned CLIP_ROW = sbck_pkg::CLIP_ROW_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  sbck_pkg::cfg_t              cfg_i,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire [sbck_pkg::PIX_W-1:0]   pixel_i,
  output logic                        item_valid_o,
  input  wire                         item_ready_i,
  output sbck_pkg::scan_item_t        item_o
);

  logic [sbck_pkg::COORD_W-1:0] col_q, col_d;
  logic [sbck_pkg::COORD_W-1:0] row_q, row_d;
  logic                         valid_q, valid_d;
  sbck_pkg::scan_item_t         item_q, item_d;

  logic [sbck_pkg::COORD_W-1:0] w, h, w_m1, h_m1, col_pos;
  logic [sbck_pkg::ROW_W-1:0]   screen_row;
  logic                         row_end, sprite_end, clip, fire;

  assign w    = (cfg_i.sprite_width  == '0) ? sbck_pkg::COORD_W'(1) : cfg_i.sprite_width;
  assign h    = (cfg_i.sprite_height == '0) ? sbck_pkg::COORD_W'(1) : cfg_i.sprite_height;
  assign w_m1 = w - sbck_pkg::COORD_W'(1);
  assign h_m1 = h - sbck_pkg::COORD_W'(1);

  assign row_end    = (col_q >= w_m1);
  assign sprite_end = row_end && (row_q >= h_m1);

  always_comb begin
    if (!cfg_i.mirror) begin
      col_pos = col_q;
    end else if (col_q >= w) begin
      col_pos = '0;
    end else begin
      col_pos = w_m1 - col_q;
    end
  end

  assign screen_row = {1'b0, cfg_i.dest_y} + {1'b0, row_q};
  assign clip       = (screen_row >= sbck_pkg::ROW_W'(CLIP_ROW));

  assign in_ready_o = !valid_q || item_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    item_d.we         = !(cfg_i.skip_zero && (pixel_i == '0)) && !clip;
    item_d.color      = (pixel_i == cfg_i.key_color) ? cfg_i.repl_color : pixel_i;
    item_d.screen_row = screen_row;
    item_d.col        = col_pos;
    item_d.last       = sprite_end;

    valid_d = in_ready_o ? in_valid_i : valid_q;

    col_d = col_q;
    row_d = row_q;
    if (fire) begin
      if (sprite_end) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + sbck_pkg::COORD_W'(1);
      end else begin
        col_d = col_q + sbck_pkg::COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  `SBCK_ASSERT_NXT(a_col_step, fire && !row_end, col_q == $past(col_q) + 9'd1,
    "column counter did not advance")
  `SBCK_ASSERT_NXT(a_row_wrap, fire && row_end, col_q == '0,
    "column counter not cleared at row end")
  `SBCK_ASSERT_NXT(a_last_restart, fire && sprite_end, (row_q == '0) && item_q.last,
    "sprite end did not restart the walk")
  `SBCK_ASSERT_NXT(a_stall_hold, valid_q && !item_ready_i, valid_q && $stable(item_q),
    "stalled item changed")

endmodule
`default_nettype wire

/* sv/sbck_emit.sv */
// Address generation and result register.
`default_nettype none
`include "sprite_blit_color_key_core_assert.svh"
module sbck_emit #(
  parameter int unsigned LINE_PIXELS = sbck_pkg::LINE_PIXELS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire [sbck_pkg::COORD_W-1:0]  dest_x_i,
  input  wire                          item_valid_i,
  output logic                         item_ready_o,
  input  sbck_pkg::scan_item_t         item_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic                         we_o,
  output logic [sbck_pkg::ADDR_W-1:0]  addr_o,
  output logic [sbck_pkg::PIX_W-1:0]   color_o,
  output logic                         last_o
);

  localparam int unsigned MULT_W = sbck_pkg::ROW_W + $clog2(LINE_PIXELS + 1);
  localparam int unsigned SUM_W  = MULT_W + 1;

  logic [MULT_W-1:0]           prod;
  logic [SUM_W-1:0]            sum;
  logic                        valid_q, valid_d, fire;
  logic                        we_q, last_q;
  logic [sbck_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic [sbck_pkg::PIX_W-1:0]  color_q, color_d;

  assign prod = MULT_W'(item_i.screen_row) * MULT_W'(LINE_PIXELS);
  assign sum  = SUM_W'(prod) + SUM_W'(dest_x_i) + SUM_W'(item_i.col);

  assign item_ready_o = !valid_q || out_ready_i;
  assign fire         = item_valid_i && item_ready_o;

  always_comb begin
    valid_d = item_ready_o ? item_valid_i : valid_q;
    addr_d  = item_i.we ? sum[sbck_pkg::ADDR_W-1:0] : '0;
    color_d = item_i.we ? item_i.color : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      we_q    <= item_i.we;
      addr_q  <= addr_d;
      color_q <= color_d;
      last_q  <= item_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign we_o        = we_q;
  assign addr_o      = addr_q;
  assign color_o     = color_q;
  assign last_o      = last_q;

  `SBCK_ASSERT_IMP(a_nowrite_zero, valid_q && !we_q, (addr_q == '0) && (color_q == '0),
    "skipped pixel carries nonzero address or color")

endmodule
`default_nettype wire

/* sv/sprite_blit_color_key_core.sv */
// Sprite blitter top level: configuration registers and stream ports.
// Returns one framebuffer write beat per sprite pixel, in order, via the input register
// and then the result register behind the row-times-line-length multiply. It takes one
// pixel per clock while the output is not stalled; the column/row counters advance once
// per input transfer. The user must write configuration through the plain write port
// only while the block is idle; the block does not enforce this.
`default_nettype none
module sprite_blit_color_key_core #(
  parameter int unsigned LINE_PIXELS = sbck_pkg::LINE_PIXELS_DEF,
  parameter int unsigned CLIP_ROW    = sbck_pkg::CLIP_ROW_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [sbck_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  wire [sbck_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire [sbck_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [7:0] pixel
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [sbck_pkg::TDATA_W-1:0]     m_axis_tdata,  // [17:0] address, [25:18] color
  output logic                             m_axis_tuser,  // [0] write_enable
  output logic                             m_axis_tlast
);

  sbck_pkg::cfg_t               cfg_q, cfg_d;
  sbck_pkg::scan_item_t         item;
  logic                         item_valid, item_ready;
  logic [sbck_pkg::ADDR_W-1:0]  addr;
  logic [sbck_pkg::PIX_W-1:0]   color;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (sbck_pkg::cfg_idx_e'(cfg_addr_i))
        sbck_pkg::CFG_DEST_X:     cfg_d.dest_x        = cfg_data_i;
        sbck_pkg::CFG_DEST_Y:     cfg_d.dest_y        = cfg_data_i;
        sbck_pkg::CFG_WIDTH:      cfg_d.sprite_width  = cfg_data_i;
        sbck_pkg::CFG_HEIGHT:     cfg_d.sprite_height = cfg_data_i;
        sbck_pkg::CFG_SKIP_ZERO:  cfg_d.skip_zero     = cfg_data_i[0];
        sbck_pkg::CFG_KEY_COLOR:  cfg_d.key_color     = cfg_data_i[sbck_pkg::PIX_W-1:0];
        sbck_pkg::CFG_REPL_COLOR: cfg_d.repl_color    = cfg_data_i[sbck_pkg::PIX_W-1:0];
        sbck_pkg::CFG_MIRROR:     cfg_d.mirror        = cfg_data_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_x        <= '0;
      cfg_q.dest_y        <= '0;
      cfg_q.sprite_width  <= sbck_pkg::COORD_W'(1);
      cfg_q.sprite_height <= sbck_pkg::COORD_W'(1);
      cfg_q.skip_zero     <= 1'b1;
      cfg_q.key_color     <= '1;
      cfg_q.repl_color    <= '0;
      cfg_q.mirror        <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sbck_scan #(
    .CLIP_ROW (CLIP_ROW)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .pixel_i      (s_axis_tdata[sbck_pkg::PIX_W-1:0]),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  sbck_emit #(
    .LINE_PIXELS (LINE_PIXELS)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dest_x_i     (cfg_q.dest_x),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .we_o         (m_axis_tuser),
    .addr_o       (addr),
    .color_o      (color),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {
    {(sbck_pkg::TDATA_W - sbck_pkg::ADDR_W - sbck_pkg::PIX_W){1'b0}}, color, addr
  };

endmodule
`default_nettype wire
